// ----- src/ialm_pkg.sv -----
// Shared types and character codes for the IPv4 allow list matcher.
// Used by every module of the block; depends on nothing else.

package ialm_pkg;

    // Characters with a meaning in the list text
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] OCTET_MAX = 8'hFF;

    // Number of dotted numbers a range suffix may hold
    localparam logic [2:0] RANGE_MAX = 3'd4;

    // Parser phase, one-hot
    typedef enum logic [5:0] {
        PH_SEEK      = 6'b000001,
        PH_OCT_START = 6'b000010,
        PH_NUM       = 6'b000100,
        PH_STAR_SKIP = 6'b001000,
        PH_POST      = 6'b010000,
        PH_RANGE_NUM = 6'b100000
    } phase_t;

    // One input beat, unpacked
    typedef struct packed {
        logic [7:0]  list_char;
        logic [31:0] check_address;
        logic        first_char;
        logic        last_char;
    } in_beat_t;

    // One verdict
    typedef struct packed {
        logic allowed;
        logic list_empty;
    } verdict_t;

    // Four octets, element 3 is the first dotted octet (bits 31..24)
    typedef logic [3:0][7:0] octets_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // True when every octet of the address lies within its bounds
    function automatic logic octets_match(input logic [31:0] addr,
                                          input octets_t lo,
                                          input octets_t hi);
        octets_t a;
        logic    ok;
        a  = addr;
        ok = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if ((a[k] < lo[k]) || (a[k] > hi[k])) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

// ----- src/ialm_in_reg.sv -----
// Input register of the allow list matcher: captures one slave-side beat.
// Depends on ialm_pkg for the beat type.

module ialm_in_reg
    import ialm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // list_char [7:0], check_address [39:8]
    input  logic        s_tuser,   // first_char
    input  logic        s_tlast,   // last_char
    output logic        beat_valid,
    output in_beat_t    beat,
    input  logic        beat_take
);

    logic     valid_reg;
    logic     valid_next;
    in_beat_t beat_reg;

    // The register can load whenever it is empty or its beat leaves this cycle.
    assign s_tready = !valid_reg || beat_take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (beat_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            beat_reg.list_char     <= s_tdata[7:0];
            beat_reg.check_address <= s_tdata[39:8];
            beat_reg.first_char    <= s_tuser;
            beat_reg.last_char     <= s_tlast;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

// ----- src/ialm_parser.sv -----
// List parser of the allow list matcher: holds the parser state and folds one list byte
// into it each cycle, producing the verdict on the last byte, which waits for a free
// output register. Depends on ialm_pkg for types, character codes and the octet compare.

module ialm_parser
    import ialm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     beat_valid,
    input  in_beat_t beat,
    output logic     beat_take,
    input  logic     result_free,
    output logic     result_valid,
    output verdict_t result
);

    logic [31:0] held_address_reg, held_address_next;
    phase_t      phase_reg, phase_next;
    logic [1:0]  octet_index_reg, octet_index_next;
    logic [7:0]  number_accum_reg, number_accum_next;
    octets_t     low_bounds_reg, low_bounds_next;
    octets_t     high_bounds_reg, high_bounds_next;
    octets_t     range_values_reg, range_values_next;
    logic [2:0]  range_count_reg, range_count_next;
    logic        match_found_reg, match_found_next;
    logic        entry_seen_reg, entry_seen_next;

    // A last byte waits until the output register can take its verdict.
    assign beat_take    = beat_valid && (!beat.last_char || result_free);
    assign result_valid = beat_take && beat.last_char;

    // Next state for one byte, then the end-of-list evaluation.
    always_comb begin
        logic [31:0] addr;
        phase_t      ph;
        logic [1:0]  oi;
        logic [7:0]  acc;
        octets_t     lo;
        octets_t     hi;
        octets_t     rv;
        logic [2:0]  rc;
        logic        mf;
        logic        es;
        logic [7:0]  c;
        logic        dig;
        logic [7:0]  acc_dig;
        logic        end_oct;
        logic        post;
        logic        eval_seek;
        logic        seek;
        logic        fin_eval;
        logic [2:0]  zero_start;

        addr      = held_address_reg;
        ph        = phase_reg;
        oi        = octet_index_reg;
        acc       = number_accum_reg;
        lo        = low_bounds_reg;
        hi        = high_bounds_reg;
        rv        = range_values_reg;
        rc        = range_count_reg;
        mf        = match_found_reg;
        es        = entry_seen_reg;
        c         = beat.list_char;
        dig       = is_digit(c);
        end_oct   = 1'b0;
        post      = 1'b0;
        eval_seek = 1'b0;
        seek      = 1'b0;
        fin_eval  = 1'b0;
        zero_start = 3'd4;

        // A first byte samples the address and starts from a clean parser.
        if (beat.first_char) begin
            addr = beat.check_address;
            ph   = PH_SEEK;
            oi   = 2'd0;
            acc  = 8'd0;
            lo   = '0;
            hi   = '0;
            rv   = '0;
            rc   = 3'd0;
            mf   = 1'b0;
            es   = 1'b0;
        end

        // Decimal accumulation wraps modulo 256.
        acc_dig = (acc << 3) + (acc << 1) + {4'd0, c[3:0]};

        // Byte handling by phase
        unique case (ph)
            PH_OCT_START: begin
                if (c == CH_STAR) begin
                    lo[~oi] = 8'd0;
                    hi[~oi] = OCTET_MAX;
                    ph      = PH_STAR_SKIP;
                end else if (dig) begin
                    acc = {4'd0, c[3:0]};
                    ph  = PH_NUM;
                end else begin
                    lo[~oi] = 8'd0;
                    hi[~oi] = 8'd0;
                    end_oct = 1'b1;
                end
            end
            PH_NUM: begin
                if (dig) begin
                    acc = acc_dig;
                end else begin
                    lo[~oi] = acc;
                    hi[~oi] = acc;
                    end_oct = 1'b1;
                end
            end
            PH_STAR_SKIP: begin
                if (oi != 2'd3) begin
                    oi = oi + 2'd1;
                    ph = PH_OCT_START;
                end else begin
                    ph = PH_POST;
                end
            end
            PH_POST: begin
                post = 1'b1;
            end
            PH_RANGE_NUM: begin
                if (dig) begin
                    acc = acc_dig;
                end else begin
                    rv[~rc[1:0]] = acc;
                    if (rc < RANGE_MAX) begin
                        rc = rc + 3'd1;
                    end
                    if ((rc < RANGE_MAX) && (c == CH_DOT)) begin
                        acc = 8'd0;
                    end else begin
                        // Range numbers replace the trailing upper bounds.
                        for (int p = 0; p < 4; p++) begin
                            if (3'(p) < rc) begin
                                hi[~(2'(p) - rc[1:0])] = rv[~2'(p)];
                            end
                        end
                        eval_seek = 1'b1;
                    end
                end
            end
            PH_SEEK: begin
                seek = 1'b1;
            end
            default: begin
                seek = 1'b1;
            end
        endcase

        // The byte that closes an octet acts as its dot.
        if (end_oct) begin
            if (oi != 2'd3) begin
                oi = oi + 2'd1;
                ph = PH_OCT_START;
            end else begin
                post = 1'b1;
            end
        end

        // After the fourth octet: a range suffix or the end of the entry.
        if (post) begin
            if (c == CH_DASH) begin
                acc = 8'd0;
                rc  = 3'd0;
                rv  = '0;
                ph  = PH_RANGE_NUM;
            end else begin
                eval_seek = 1'b1;
            end
        end

        if (eval_seek) begin
            if (octets_match(addr, lo, hi)) begin
                mf = 1'b1;
            end
            seek = 1'b1;
        end

        // A digit opens a new entry.
        if (seek) begin
            if (dig) begin
                es  = 1'b1;
                oi  = 2'd0;
                acc = {4'd0, c[3:0]};
                rc  = 3'd0;
                rv  = '0;
                ph  = PH_NUM;
            end else begin
                ph = PH_SEEK;
            end
        end

        // End of list: close an open entry, missing octets count as zero.
        if (beat.last_char) begin
            unique case (ph)
                PH_OCT_START: begin
                    zero_start = {1'b0, oi};
                    fin_eval   = 1'b1;
                end
                PH_NUM: begin
                    lo[~oi]    = acc;
                    hi[~oi]    = acc;
                    zero_start = {1'b0, oi} + 3'd1;
                    fin_eval   = 1'b1;
                end
                PH_STAR_SKIP: begin
                    zero_start = {1'b0, oi} + 3'd1;
                    fin_eval   = 1'b1;
                end
                PH_POST: begin
                    fin_eval = 1'b1;
                end
                PH_RANGE_NUM: begin
                    rv[~rc[1:0]] = acc;
                    if (rc < RANGE_MAX) begin
                        rc = rc + 3'd1;
                    end
                    for (int p = 0; p < 4; p++) begin
                        if (3'(p) < rc) begin
                            hi[~(2'(p) - rc[1:0])] = rv[~2'(p)];
                        end
                    end
                    fin_eval = 1'b1;
                end
                PH_SEEK: begin
                    fin_eval = 1'b0;
                end
                default: begin
                    fin_eval = 1'b0;
                end
            endcase
            for (int k = 0; k < 4; k++) begin
                if (3'(k) >= zero_start) begin
                    lo[~2'(k)] = 8'd0;
                    hi[~2'(k)] = 8'd0;
                end
            end
            if (fin_eval && octets_match(addr, lo, hi)) begin
                mf = 1'b1;
            end
        end

        result.allowed    = mf || !es;
        result.list_empty = !es;

        held_address_next = addr;
        if (beat.last_char) begin
            // The verdict is out, so the parser starts afresh.
            phase_next        = PH_SEEK;
            octet_index_next  = 2'd0;
            number_accum_next = 8'd0;
            low_bounds_next   = '0;
            high_bounds_next  = '0;
            range_values_next = '0;
            range_count_next  = 3'd0;
            match_found_next  = 1'b0;
            entry_seen_next   = 1'b0;
        end else begin
            phase_next        = ph;
            octet_index_next  = oi;
            number_accum_next = acc;
            low_bounds_next   = lo;
            high_bounds_next  = hi;
            range_values_next = rv;
            range_count_next  = rc;
            match_found_next  = mf;
            entry_seen_next   = es;
        end
    end

    // State registers, updated only when a byte is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_address_reg <= '0;
            phase_reg        <= PH_SEEK;
            octet_index_reg  <= 2'd0;
            number_accum_reg <= 8'd0;
            low_bounds_reg   <= '0;
            high_bounds_reg  <= '0;
            range_values_reg <= '0;
            range_count_reg  <= 3'd0;
            match_found_reg  <= 1'b0;
            entry_seen_reg   <= 1'b0;
        end else if (beat_take) begin
            held_address_reg <= held_address_next;
            phase_reg        <= phase_next;
            octet_index_reg  <= octet_index_next;
            number_accum_reg <= number_accum_next;
            low_bounds_reg   <= low_bounds_next;
            high_bounds_reg  <= high_bounds_next;
            range_values_reg <= range_values_next;
            range_count_reg  <= range_count_next;
            match_found_reg  <= match_found_next;
            entry_seen_reg   <= entry_seen_next;
        end
    end

    // A byte is only taken when one is held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        beat_take |-> beat_valid)
        else $error("parser took a byte that was not held");

    // A verdict leaves the parser cleared for the next list.
    assert property (@(posedge aclk) disable iff (!aresetn)
        result_valid |=> (phase_reg == PH_SEEK) && !entry_seen_reg && !match_found_reg)
        else $error("parser not cleared after a verdict");

    // An empty list is always allowed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (result_valid && result.list_empty) |-> result.allowed)
        else $error("empty list gave a refusal");

    // The range count never passes four.
    assert property (@(posedge aclk) disable iff (!aresetn)
        range_count_reg <= RANGE_MAX)
        else $error("range count out of bounds");

endmodule

// ----- src/ialm_out_reg.sv -----
// Output register of the allow list matcher: holds one verdict beat until the
// master side takes it. Depends on ialm_pkg for the verdict type.

module ialm_out_reg
    import ialm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       result_valid,
    input  verdict_t   result,
    output logic       result_free,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata     // allowed [0], list_empty [1], zeros [7:2]
);

    logic     valid_reg;
    logic     valid_next;
    verdict_t verdict_reg;

    // A new verdict may enter when the register is empty or draining now.
    assign result_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (result_valid) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (result_valid) begin
            verdict_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, verdict_reg.list_empty, verdict_reg.allowed};

endmodule

// ----- src/ip_allow_list_matcher.sv -----
// Top level of the IPv4 allow list matcher: input register, list parser and
// output register. Depends on ialm_pkg, ialm_in_reg, ialm_parser, ialm_out_reg.

// The allow list text streams in one character per beat, with the address to
// check carried on the first beat (tuser high) and the list closed by tlast.
// The block takes one beat in every clock cycle, back to back, as long as the
// verdict side keeps up. Each byte waits in the input register, where the parser
// folds it into its state. The verdict is registered in the output register
// when the parser takes the last list byte from the input register, so the
// verdict beat is offered from there. The rate is set by the parser state update,
// which consumes one byte per cycle while bytes are held. A last byte whose verdict
// cannot yet enter the output register holds the input side.

module ip_allow_list_matcher
    import ialm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // list_char [7:0], check_address [39:8]
    input  logic        s_tuser,   // first_char
    input  logic        s_tlast,   // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // allowed [0], list_empty [1], zeros [7:2]
);

    logic     beat_valid;
    in_beat_t beat;
    logic     beat_take;
    logic     result_free;
    logic     result_valid;
    verdict_t result;

    // Slave-side beat capture
    ialm_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_take  (beat_take)
    );

    // Parser and matcher
    ialm_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .beat_valid   (beat_valid),
        .beat         (beat),
        .beat_take    (beat_take),
        .result_free  (result_free),
        .result_valid (result_valid),
        .result       (result)
    );

    // Verdict register on the master side
    ialm_out_reg u_out_reg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .result_valid (result_valid),
        .result       (result),
        .result_free  (result_free),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the IPv4 allow list matcher: streams list text with
// random gaps and stalls and checks every verdict against an in-bench parser.
// Depends on ialm_pkg and ip_allow_list_matcher.

module tb_top
    import ialm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // list_char [7:0], check_address [39:8]
    logic        s_tuser  = 1'b0; // first_char
    logic        s_tlast  = 1'b0; // last_char
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // allowed [0], list_empty [1], zeros [7:2]

    ip_allow_list_matcher u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Beats waiting to be sent and verdicts waiting to arrive
    in_beat_t    beats_pending[$];
    verdict_t    verdicts_due[$];
    logic [7:0]  list_txt[$];
    int unsigned error_count = 0;

    // Parser state of the checking model
    logic [31:0] addr_held;
    phase_t      parse_ph;
    int unsigned oct_idx;
    logic [7:0]  num_acc;
    logic [31:0] lo_bounds;
    logic [31:0] hi_bounds;
    logic [31:0] rng_vals;
    int unsigned rng_cnt;
    bit          hit;
    bit          seen;

    task automatic flag_mismatch(input string what);
        error_count++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    function automatic bit digit_char(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Octet 0 is the first dotted octet, held in bits 31..24
    function automatic int unsigned shift_of(input int unsigned i);
        return (3 - (i % 4)) * 8;
    endfunction

    function void add_digit(input logic [7:0] c);
        num_acc = 8'(num_acc * 10 + (c - CH_ZERO));
    endfunction

    function void set_hi(input int unsigned i, input logic [7:0] v);
        hi_bounds[shift_of(i) +: 8] = v;
    endfunction

    function void set_oct(input int unsigned i, input logic [7:0] lo, input logic [7:0] hi);
        lo_bounds[shift_of(i) +: 8] = lo;
        set_hi(i, hi);
    endfunction

    function void zero_tail(input int unsigned i);
        for (int unsigned k = i; k < 4; k++) begin
            set_oct(k, 8'd0, 8'd0);
        end
    endfunction

    function void store_rng();
        rng_vals[shift_of(rng_cnt) +: 8] = num_acc;
        if (rng_cnt < 4) begin
            rng_cnt++;
        end
    endfunction

    // Range numbers replace the trailing upper bounds
    function void apply_rng();
        int unsigned n;
        n = (rng_cnt > 4) ? 4 : rng_cnt;
        for (int unsigned pos = 0; pos < n; pos++) begin
            set_hi(4 - n + pos, rng_vals[shift_of(pos) +: 8]);
        end
    endfunction

    // Each address octet is checked against its own bounds
    function void judge_entry();
        bit         ok;
        logic [7:0] a;
        ok = 1'b1;
        for (int unsigned k = 0; k < 4; k++) begin
            a = addr_held[shift_of(k) +: 8];
            if (a < lo_bounds[shift_of(k) +: 8] || a > hi_bounds[shift_of(k) +: 8]) begin
                ok = 1'b0;
            end
        end
        if (ok) begin
            hit = 1'b1;
        end
        parse_ph = PH_SEEK;
    endfunction

    function void seek_entry(input logic [7:0] c);
        if (digit_char(c)) begin
            seen     = 1'b1;
            oct_idx  = 0;
            num_acc  = 8'd0;
            add_digit(c);
            rng_cnt  = 0;
            rng_vals = '0;
            parse_ph = PH_NUM;
        end else begin
            parse_ph = PH_SEEK;
        end
    endfunction

    function void after_entry(input logic [7:0] c);
        if (c == CH_DASH) begin
            num_acc  = 8'd0;
            rng_cnt  = 0;
            rng_vals = '0;
            parse_ph = PH_RANGE_NUM;
        end else begin
            judge_entry();
            seek_entry(c);
        end
    endfunction

    function void close_octet(input logic [7:0] c);
        if (oct_idx < 3) begin
            oct_idx++;
            parse_ph = PH_OCT_START;
        end else begin
            after_entry(c);
        end
    endfunction

    function void parse_byte(input logic [7:0] c);
        case (parse_ph)
            PH_OCT_START: begin
                if (c == CH_STAR) begin
                    set_oct(oct_idx, 8'd0, OCTET_MAX);
                    parse_ph = PH_STAR_SKIP;
                end else if (digit_char(c)) begin
                    num_acc  = 8'd0;
                    add_digit(c);
                    parse_ph = PH_NUM;
                end else begin
                    set_oct(oct_idx, 8'd0, 8'd0);
                    close_octet(c);
                end
            end
            PH_NUM: begin
                if (digit_char(c)) begin
                    add_digit(c);
                end else begin
                    set_oct(oct_idx, num_acc, num_acc);
                    close_octet(c);
                end
            end
            PH_STAR_SKIP: begin
                // The byte after a star is dropped unseen
                if (oct_idx < 3) begin
                    oct_idx++;
                    parse_ph = PH_OCT_START;
                end else begin
                    parse_ph = PH_POST;
                end
            end
            PH_POST: begin
                after_entry(c);
            end
            PH_RANGE_NUM: begin
                if (digit_char(c)) begin
                    add_digit(c);
                end else begin
                    store_rng();
                    if (rng_cnt < 4 && c == CH_DOT) begin
                        num_acc = 8'd0;
                    end else begin
                        apply_rng();
                        judge_entry();
                        seek_entry(c);
                    end
                end
            end
            default: begin
                seek_entry(c);
            end
        endcase
    endfunction

    // An entry cut short by the end of the list has its missing octets as zero
    function void close_list();
        case (parse_ph)
            PH_OCT_START: begin
                zero_tail(oct_idx);
                judge_entry();
            end
            PH_NUM: begin
                set_oct(oct_idx, num_acc, num_acc);
                zero_tail(oct_idx + 1);
                judge_entry();
            end
            PH_STAR_SKIP: begin
                zero_tail(oct_idx + 1);
                judge_entry();
            end
            PH_POST: begin
                judge_entry();
            end
            PH_RANGE_NUM: begin
                store_rng();
                apply_rng();
                judge_entry();
            end
            default: begin
            end
        endcase
    endfunction

    function void clear_parser();
        parse_ph  = PH_SEEK;
        oct_idx   = 0;
        num_acc   = 8'd0;
        lo_bounds = '0;
        hi_bounds = '0;
        rng_vals  = '0;
        rng_cnt   = 0;
        hit       = 1'b0;
        seen      = 1'b0;
    endfunction

    // Fold one accepted beat into the model and queue any verdict it causes
    function void predict_beat(input in_beat_t b);
        verdict_t v;
        if (b.first_char) begin
            addr_held = b.check_address;
            clear_parser();
        end
        parse_byte(b.list_char);
        if (b.last_char) begin
            close_list();
            v.allowed    = hit || !seen;
            v.list_empty = !seen;
            verdicts_due.push_back(v);
            clear_parser();
        end
    endfunction

    function automatic int unsigned draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 3);
    endfunction

    // Input side: one beat at a time from the pending queue, with random gaps
    int unsigned send_gap  = 0;
    bit          send_calm = 1'b0;
    in_beat_t    next_beat;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_beat('{list_char: s_tdata[7:0], check_address: s_tdata[39:8],
                               first_char: s_tuser, last_char: s_tlast});
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (beats_pending.size() > 0) begin
                    next_beat = beats_pending.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= {next_beat.check_address, next_beat.list_char};
                    s_tuser   <= next_beat.first_char;
                    s_tlast   <= next_beat.last_char;
                    send_gap  <= draw_wait(send_calm);
                    if ($urandom_range(0, 99) == 0) begin
                        send_calm <= !send_calm;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Verdict side: check each beat, then stall at random unless in a calm spell
    int unsigned recv_gap  = 0;
    bit          recv_calm = 1'b0;
    int unsigned new_gap;
    verdict_t    want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else if (m_tvalid && m_tready) begin
            if (verdicts_due.size() == 0) begin
                flag_mismatch($sformatf("verdict beat 0x%02h with none expected", m_tdata));
            end else begin
                want = verdicts_due.pop_front();
                if (m_tdata[0] !== want.allowed) begin
                    flag_mismatch($sformatf("allowed is %b, expected %b",
                                            m_tdata[0], want.allowed));
                end
                if (m_tdata[1] !== want.list_empty) begin
                    flag_mismatch($sformatf("list_empty is %b, expected %b",
                                            m_tdata[1], want.list_empty));
                end
                if (m_tdata[7:2] !== 6'd0) begin
                    flag_mismatch($sformatf("padding bits are %b, expected zero",
                                            m_tdata[7:2]));
                end
            end
            new_gap = draw_wait(recv_calm);
            recv_gap <= new_gap;
            m_tready <= (new_gap == 0);
            if ($urandom_range(0, 7) == 0) begin
                recv_calm <= !recv_calm;
            end
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_tready <= (recv_gap == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Queue the bytes of list_txt as one list
    task automatic enqueue_list(input logic [31:0] addr, input bit with_first);
        in_beat_t b;
        for (int i = 0; i < list_txt.size(); i++) begin
            b.list_char     = list_txt[i];
            b.first_char    = (i == 0) ? with_first : ($urandom_range(0, 199) == 0);
            b.last_char     = (i == list_txt.size() - 1);
            b.check_address = (i == 0) ? addr : $urandom();
            beats_pending.push_back(b);
        end
    endtask

    task automatic set_text(input string s);
        list_txt.delete();
        for (int i = 0; i < s.len(); i++) begin
            list_txt.push_back(s[i]);
        end
    endtask

    task automatic add_number(input int unsigned v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++) begin
            list_txt.push_back(s[i]);
        end
    endtask

    // Small values and the extremes, so that entries often match
    function automatic int unsigned pick_octet();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom_range(0, 3);
            5, 6:          return 255;
            7, 8:          return $urandom_range(0, 255);
            default:       return $urandom_range(256, 999);
        endcase
    endfunction

    // Build one random list in list_txt and pick the address to test against it
    task automatic make_list(output logic [31:0] addr);
        logic [31:0] entry_addr;
        int unsigned n_entries;
        int unsigned n_range;
        int unsigned v;
        int unsigned cut;
        list_txt.delete();
        entry_addr = '0;
        case ($urandom_range(0, 9))
            0: begin
                // Pure noise
                repeat ($urandom_range(1, 12)) list_txt.push_back(8'($urandom_range(0, 255)));
            end
            1: begin
                // Text with no digit at all
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 1)) begin
                        list_txt.push_back(8'($urandom_range(8'h3A, 8'hFF)));
                    end else begin
                        list_txt.push_back(8'($urandom_range(8'h00, 8'h2F)));
                    end
                end
            end
            default: begin
                // Well-formed entries with random content
                n_entries = $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0) begin
                    list_txt.push_back(" ");
                end
                for (int e = 0; e < n_entries; e++) begin
                    for (int o = 0; o < 4; o++) begin
                        if ($urandom_range(0, 3) == 0) begin
                            list_txt.push_back(CH_STAR);
                            v = $urandom_range(0, 255);
                        end else begin
                            v = pick_octet();
                            add_number(v);
                        end
                        if (e == 0) begin
                            entry_addr[shift_of(o) +: 8] = v[7:0];
                        end
                        if (o < 3) begin
                            list_txt.push_back(CH_DOT);
                        end
                    end
                    if ($urandom_range(0, 9) < 3) begin
                        list_txt.push_back(CH_DASH);
                        n_range = $urandom_range(1, 4);
                        for (int r = 0; r < n_range; r++) begin
                            if (r > 0) begin
                                list_txt.push_back(CH_DOT);
                            end
                            add_number(pick_octet());
                        end
                    end
                    if (e < n_entries - 1) begin
                        case ($urandom_range(0, 3))
                            0: list_txt.push_back(",");
                            1: list_txt.push_back(" ");
                            2: list_txt.push_back(";");
                            default: begin
                                list_txt.push_back(",");
                                list_txt.push_back(" ");
                            end
                        endcase
                    end
                end
                // Sometimes the list stops part way through an entry
                if ($urandom_range(0, 6) == 0 && list_txt.size() > 1) begin
                    cut = $urandom_range(1, list_txt.size() - 1);
                    repeat (cut) void'(list_txt.pop_back());
                end
                // Sprinkle a few stray bytes
                foreach (list_txt[i]) begin
                    if ($urandom_range(0, 39) == 0) begin
                        list_txt[i] = 8'($urandom_range(0, 255));
                    end
                end
            end
        endcase
        if ($urandom_range(0, 1)) begin
            addr = entry_addr;
        end else begin
            for (int o = 0; o < 4; o++) begin
                addr[shift_of(o) +: 8] = ($urandom_range(0, 2) == 0) ? 8'(pick_octet()) :
                                         8'($urandom_range(0, 255));
            end
        end
    endtask

    // Run limit
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Stimulus, reset and end of run
    initial begin
        logic [31:0] addr;
        int unsigned n_random;
        addr_held = '0;
        clear_parser();

        // Directed lists: first one without a start flag, so the reset address is used
        set_text("0");
        enqueue_list(32'h0000_0000, 1'b0);
        // A single zero byte carrying both flags: a list with no entry
        list_txt.delete();
        list_txt.push_back(8'h00);
        enqueue_list(32'hFFFF_FFFF, 1'b1);
        set_text("*.*.*.*");
        enqueue_list($urandom(), 1'b1);
        set_text("1.2.3.4-9");
        enqueue_list(32'h0102_0307, 1'b1);
        // Decimal overflow wraps, and missing octets count as zero
        set_text("256");
        enqueue_list(32'h0000_0000, 1'b1);

        // Random lists, a few without a start flag
        n_random = 0;
        while (n_random < 2000) begin
            make_list(addr);
            n_random += list_txt.size();
            enqueue_list(addr, $urandom_range(0, 19) != 0);
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (beats_pending.size() != 0 || s_tvalid) @(posedge aclk);
        while (verdicts_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/ialm_pkg.sv
src/ialm_in_reg.sv
src/ialm_parser.sv
src/ialm_out_reg.sv
src/ip_allow_list_matcher.sv
verif/tb_top.sv
